// ----- rtl/lcsr_pkg.sv -----
// Shared types and constants for the load-cell serial reader.
`default_nettype none
package lcsr_pkg;

  // Output sample width and configuration register geometry
  localparam int SAMPLE_W = 24;
  localparam int THR_W    = 24;
  localparam int GAIN_W   = 2;
  localparam int CFG_W    = 24;
  localparam int IDX_W    = 2;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_GAIN  = 2'd0;
  localparam logic [IDX_W-1:0] REG_THR   = 2'd1;
  localparam logic [IDX_W-1:0] REG_PDOWN = 2'd2;

  // Reset values of the gain and threshold registers
  localparam logic [GAIN_W-1:0] GAIN_RESET = 2'd3;
  localparam logic [THR_W-1:0]  THR_RESET  = 24'd14000;

  // Per-tick status from the sequencer
  typedef struct packed {
    logic sck;
    logic done;
  } seq_stat_t;

  // One result transaction
  typedef struct packed {
    logic                       sck;
    logic                       sample_valid;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       step;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/load_cell_serial_reader_step_detect.sv -----
// Top level of the load-cell serial reader with step detection.
// Each input transaction is one half-period tick of the converter's serial clock and
// carries the data line level; each tick yields exactly one output transaction with
// the clock level to drive, plus a sample and step flag on the tick that ends a read.
// A read is DATA_BITS pulses (high tick, low tick) sampled MSB first, then 1 to 3
// gain pulses; the sample appears on the low tick of the last gain pulse. The block
// takes one tick per clock cycle while in_ready is high, and registers each tick's result
// in the output register; the sequencer next-state logic and the step compare are combinational.
// A two-deep output register absorbs one more tick under output stall, then drops in_ready.
`default_nettype none
module load_cell_serial_reader_step_detect import lcsr_pkg::*; #(
  parameter int DATA_BITS = 24
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic [IDX_W-1:0]           wr_index,
  input  wire logic [CFG_W-1:0]           wr_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       dout,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            sck,
  output logic                            sample_valid,
  output logic signed [SAMPLE_W-1:0]      sample,
  output logic                            step
);

  logic [GAIN_W-1:0]    gain_pulses;
  logic [THR_W-1:0]     step_threshold;
  logic                 power_down;
  logic                 accept;
  logic                 skid_valid;
  seq_stat_t            stat;
  logic [DATA_BITS-1:0] word;
  res_t                 res_c;
  res_t                 res_q;

  assign accept = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_pulses    <= GAIN_RESET;
      step_threshold <= THR_RESET;
      power_down     <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_GAIN:  gain_pulses    <= wr_data[GAIN_W-1:0];
        REG_THR:   step_threshold <= wr_data[THR_W-1:0];
        REG_PDOWN: power_down     <= wr_data[0];
        default:   ;
      endcase
    end
  end

  lcsr_seq #(.DATA_BITS(DATA_BITS)) u_seq (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .dout        (dout),
    .gain_pulses (gain_pulses),
    .power_down  (power_down),
    .stat        (stat),
    .word        (word)
  );

  lcsr_step #(.DATA_BITS(DATA_BITS)) u_step (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .stat           (stat),
    .word           (word),
    .step_threshold (step_threshold),
    .res            (res_c)
  );

  lcsr_obuf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .res_in     (res_c),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .res_out    (res_q),
    .skid_valid (skid_valid)
  );

  assign sck          = res_q.sck;
  assign sample_valid = res_q.sample_valid;
  assign sample       = res_q.sample;
  assign step         = res_q.step;

  // Skid stage only fills behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage full with output register empty");

  // A read completes on a low tick of the serial clock
  a_done_low_tick: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> !stat.sck)
    else $error("read completed on a high clock tick");

  // No step or sample value without a completed read
  a_quiet_without_sample: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !sample_valid) |-> (!step && sample == '0))
    else $error("step or sample set without a completed read");

endmodule
`default_nettype wire

// ----- rtl/lcsr_seq.sv -----
// Serial clock sequencer: data pulses, gain pulses and data-line shift register.
`default_nettype none
module lcsr_seq import lcsr_pkg::*; #(
  parameter int DATA_BITS = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire logic                 dout,
  input  wire logic [GAIN_W-1:0]    gain_pulses,
  input  wire logic                 power_down,
  output seq_stat_t                 stat,
  output logic      [DATA_BITS-1:0] word
);

  localparam int CW = $clog2(DATA_BITS + 1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_GAIN = 2'd2;

  logic [1:0]           phase, phase_next;
  logic [CW-1:0]        cnt, cnt_next, cnt_inc;
  logic                 half, half_next;
  logic [DATA_BITS-1:0] shift, shift_next;
  logic [GAIN_W-1:0]    gain_eff;

  // A gain setting of zero behaves as one pulse
  assign gain_eff = (gain_pulses == '0) ? GAIN_W'(1) : gain_pulses;
  assign cnt_inc  = cnt + CW'(1);

  // Next-state logic for one tick
  always_comb begin
    phase_next = phase;
    cnt_next   = cnt;
    half_next  = half;
    shift_next = shift;
    stat.sck   = 1'b0;
    stat.done  = 1'b0;
    case (phase)
      PH_DATA: begin
        if (!half) begin
          stat.sck   = 1'b1;
          shift_next = {shift[DATA_BITS-2:0], dout};
          half_next  = 1'b1;
        end else begin
          half_next = 1'b0;
          cnt_next  = cnt_inc;
          if (cnt_inc >= CW'(DATA_BITS)) begin
            phase_next = PH_GAIN;
            cnt_next   = '0;
          end
        end
      end
      PH_GAIN: begin
        if (!half) begin
          stat.sck  = 1'b1;
          half_next = 1'b1;
        end else begin
          half_next = 1'b0;
          cnt_next  = cnt_inc;
          if (cnt_inc >= CW'(gain_eff)) begin
            stat.done  = 1'b1;
            phase_next = PH_IDLE;
            cnt_next   = '0;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
        half_next  = 1'b0;
        cnt_next   = '0;
        if (power_down) begin
          stat.sck = 1'b1;
        end else if (!dout) begin
          phase_next = PH_DATA;
          shift_next = '0;
        end
      end
    endcase
  end

  // State registers advance only on an accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      cnt   <= '0;
      half  <= 1'b0;
      shift <= '0;
    end else if (accept) begin
      phase <= phase_next;
      cnt   <= cnt_next;
      half  <= half_next;
      shift <= shift_next;
    end
  end

  assign word = shift;

endmodule
`default_nettype wire

// ----- rtl/lcsr_step.sv -----
// Sample conversion, step detection and previous-sample register.
`default_nettype none
module lcsr_step import lcsr_pkg::*; #(
  parameter int DATA_BITS = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire seq_stat_t            stat,
  input  wire logic [DATA_BITS-1:0] word,
  input  wire logic [THR_W-1:0]     step_threshold,
  output res_t                      res
);

  localparam int SW = (DATA_BITS > SAMPLE_W) ? DATA_BITS : SAMPLE_W;
  localparam int DW = SAMPLE_W + 2;

  localparam logic signed [SW-1:0] SAT_MAX = SW'(24'sh7FFFFF);
  localparam logic signed [SW-1:0] SAT_MIN = SW'(24'sh800000);

  logic signed [SW-1:0]       wide;
  logic signed [SAMPLE_W-1:0] sample_c;
  logic signed [SAMPLE_W-1:0] prev_sample;
  logic signed [DW-1:0]       diff;
  logic                       step_c;

  // Sign-extend the word, saturating when it is wider than the sample
  always_comb begin
    wide = SW'($signed(word));
    if (wide > SAT_MAX) begin
      sample_c = SAT_MAX[SAMPLE_W-1:0];
    end else if (wide < SAT_MIN) begin
      sample_c = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      sample_c = wide[SAMPLE_W-1:0];
    end
  end

  // Rise test on full-range values, no wrap
  assign diff   = DW'(sample_c) - $signed({2'b00, step_threshold});
  assign step_c = (sample_c != '1) && (diff > DW'(prev_sample));

  // Result for this tick
  always_comb begin
    res.sck          = stat.sck;
    res.sample_valid = stat.done;
    res.sample       = stat.done ? sample_c : '0;
    res.step         = stat.done & step_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample <= '0;
    end else if (accept && stat.done) begin
      prev_sample <= sample_c;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lcsr_obuf.sv -----
// Output register with a skid stage so one more input tick is taken under a stall.
`default_nettype none
module lcsr_obuf import lcsr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic accept,
  input  wire res_t res_in,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      res_out,
  output logic      skid_valid
);

  res_t out_res;
  res_t skid_res;

  assign in_ready = !skid_valid;
  assign res_out  = out_res;

  // Control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!accept) begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      if (accept) begin
        out_valid <= 1'b1;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (accept) begin
        out_res <= res_in;
      end
    end else if (!out_valid) begin
      if (accept) begin
        out_res <= res_in;
      end
    end else if (accept) begin
      skid_res <= res_in;
    end
  end

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the load-cell serial reader with step detection.
`timescale 1ns / 100ps

module tb;
  import lcsr_pkg::*;

  localparam int DATA_BITS   = 24;
  localparam int HOLD_CYCLES = 60;
  localparam int LIMIT       = 400000;

  // Sequencer phase of the local readout predictor
  typedef enum logic [1:0] {SEQ_IDLE, SEQ_DATA, SEQ_GAIN} seq_phase_e;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       wr_en = 1'b0;
  logic [IDX_W-1:0]           wr_index = REG_GAIN;
  logic [CFG_W-1:0]           wr_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       dout = 1'b1;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       sck;
  logic                       sample_valid;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       step;

  load_cell_serial_reader_step_detect #(.DATA_BITS(DATA_BITS)) dut (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .dout         (dout),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sck          (sck),
    .sample_valid (sample_valid),
    .sample       (sample),
    .step         (step)
  );

  // Line levels waiting to be sent, and tick results still owed by the block
  bit   dout_q[$];
  res_t readout_q[$];

  // Register copies
  logic [GAIN_W-1:0] cfg_gain  = GAIN_RESET;
  logic [THR_W-1:0]  cfg_thr   = THR_RESET;
  logic              cfg_pdown = 1'b0;

  // Predictor state
  seq_phase_e                 phase;
  logic                       half_high;
  logic [4:0]                 pulses;
  logic [DATA_BITS-1:0]       word;
  logic signed [SAMPLE_W-1:0] last_sample;

  int  send_gap = 0;
  int  recv_gap = 0;
  bit  calm     = 1'b0;
  bit  hold_go  = 1'b0;
  int  hold_cnt = 0;
  int  errors   = 0;
  int  cycles   = 0;
  wire holding  = hold_go && (hold_cnt < HOLD_CYCLES);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // One serial tick: clock level, shifting, and the sample with its step flag
  function automatic res_t advance_readout(input logic d);
    res_t                       r;
    logic [4:0]                 g;
    logic signed [SAMPLE_W-1:0] s;
    r = '0;
    g = (cfg_gain == 0) ? 5'd1 : 5'(cfg_gain);
    case (phase)
      SEQ_DATA: begin
        if (!half_high) begin
          r.sck = 1'b1;
          word = {word[DATA_BITS-2:0], d};
          half_high = 1'b1;
        end else begin
          half_high = 1'b0;
          pulses = pulses + 5'd1;
          if (pulses >= DATA_BITS) begin
            phase = SEQ_GAIN;
            pulses = '0;
          end
        end
      end
      SEQ_GAIN: begin
        if (!half_high) begin
          r.sck = 1'b1;
          half_high = 1'b1;
        end else begin
          half_high = 1'b0;
          pulses = pulses + 5'd1;
          if (pulses >= g) begin
            s = signed'(word);
            r.sample_valid = 1'b1;
            r.sample = s;
            // all-ones word never counts as a step; compare without wrap
            r.step = (s != -1) &&
                     ((longint'(s) - longint'(cfg_thr)) > longint'(last_sample));
            last_sample = s;
            phase = SEQ_IDLE;
            pulses = '0;
          end
        end
      end
      default: begin
        phase = SEQ_IDLE;
        half_high = 1'b0;
        pulses = '0;
        if (cfg_pdown) begin
          r.sck = 1'b1;
        end else if (!d) begin
          phase = SEQ_DATA;
          word = '0;
        end
      end
    endcase
    return r;
  endfunction

  // Stimulus builders
  function automatic void queue_ones(input int n);
    for (int i = 0; i < n; i++) dout_q.push_back(1'b1);
  endfunction

  // Random line levels, then enough idle-high ticks to finish any read they start
  function automatic void queue_noise(input int n);
    for (int i = 0; i < n; i++) dout_q.push_back(1'($urandom_range(0, 1)));
    queue_ones(56);
  endfunction

  // A full read: ready tick, data pulses MSB first, then the gain pulses
  function automatic void queue_read(input logic [SAMPLE_W-1:0] w);
    int g;
    g = (cfg_gain == 0) ? 1 : int'(cfg_gain);
    dout_q.push_back(1'b0);
    for (int b = DATA_BITS - 1; b >= 0; b--) begin
      dout_q.push_back(w[b]);
      dout_q.push_back(1'($urandom_range(0, 1)));
    end
    for (int i = 0; i < 2 * g; i++) dout_q.push_back(1'($urandom_range(0, 1)));
  endfunction

  // Two reads rising by the threshold or one more; random reads if none can fit
  function automatic void queue_step_pair();
    longint lim;
    longint a;
    lim = 8388607 - longint'(cfg_thr) - 1;
    if (lim < -8388608) begin
      queue_read(SAMPLE_W'($urandom));
      queue_read(SAMPLE_W'($urandom));
    end else begin
      a = -8388608 + longint'($urandom_range(0, 32'(lim + 8388608)));
      queue_read(a[SAMPLE_W-1:0]);
      queue_read(SAMPLE_W'(a + longint'(cfg_thr) + longint'($urandom_range(0, 1))));
    end
  endfunction

  function automatic logic [SAMPLE_W-1:0] extreme_word();
    case ($urandom_range(0, 3))
      0:       return 24'h000000;
      1:       return 24'h7FFFFF;
      2:       return 24'h800000;
      default: return 24'hFFFFFF;
    endcase
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_GAIN:  cfg_gain  = val[GAIN_W-1:0];
      REG_THR:   cfg_thr   = val[THR_W-1:0];
      REG_PDOWN: cfg_pdown = val[0];
      default: ;
    endcase
  endtask

  // Block until nothing is queued, offered or owed
  task automatic wait_quiet();
    @(negedge clk);
    while (dout_q.size() != 0 || in_valid || readout_q.size() != 0) @(negedge clk);
  endtask

  // Driver: input transactions, with bursts of idling
  always @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      send_gap    <= 0;
      phase       = SEQ_IDLE;
      half_high   = 1'b0;
      pulses      = '0;
      word        = '0;
      last_sample = '0;
    end else begin
      if (in_valid && in_ready) readout_q.push_back(advance_readout(dout));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 15) == 0) begin
          send_gap <= $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else if (dout_q.size() != 0) begin
          in_valid <= 1'b1;
          dout     <= dout_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (!rst && holding) hold_cnt <= hold_cnt + 1;
  end

  // Monitor: output transactions checked against the oldest owed result
  always @(posedge clk) begin : monitor
    res_t want;
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (readout_q.size() == 0) begin
          $error("unexpected output transaction: sck %0d valid %0d sample %0d step %0d",
                 sck, sample_valid, sample, step);
          errors++;
        end else begin
          want = readout_q.pop_front();
          if (sck !== want.sck) begin
            $error("sck: expected %0d, got %0d", want.sck, sck);
            errors++;
          end
          if (sample_valid !== want.sample_valid) begin
            $error("sample_valid: expected %0d, got %0d", want.sample_valid, sample_valid);
            errors++;
          end
          if (sample !== want.sample) begin
            $error("sample: expected %0d, got %0d", want.sample, sample);
            errors++;
          end
          if (step !== want.step) begin
            $error("step: expected %0d, got %0d", want.step, step);
            errors++;
          end
        end
      end
      if (holding) begin
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap  <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        recv_gap  <= $urandom_range(0, 9);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Sequence of the run
  initial begin : run
    int target;
    int pick;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: the all-ones exclusion and the threshold edge
    queue_ones(3);
    queue_read(24'hFFFFFF);
    queue_read(24'd13999);
    queue_read(24'd28000);
    wait_quiet();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_GAIN, 24'd1);
          write_reg(REG_THR, 24'd0);
        end
        1: begin
          write_reg(REG_GAIN, 24'd2);
          write_reg(REG_THR, 24'hFFFFFF);
        end
        2: begin
          // gain of zero, plus a powered-down stretch of random line levels
          write_reg(REG_GAIN, 24'd0);
          write_reg(REG_THR, CFG_W'($urandom));
          write_reg(REG_PDOWN, 24'd1);
          @(negedge clk);
          for (int i = 0; i < 20; i++) dout_q.push_back(1'($urandom_range(0, 1)));
          wait_quiet();
          write_reg(REG_PDOWN, 24'd0);
        end
        3: begin
          write_reg(REG_GAIN, 24'd3);
          write_reg(REG_THR, CFG_W'($urandom_range(0, 20000)));
        end
        default: begin
          write_reg(REG_GAIN, CFG_W'($urandom_range(0, 3)));
          write_reg(REG_THR, CFG_W'($urandom));
        end
      endcase
      @(negedge clk);
      if (ph == 0) hold_go = 1'b1;
      if (ph == 4) calm = 1'b1;

      target = dout_q.size() + 40;
      while (dout_q.size() < target) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          queue_noise($urandom_range(1, 12));
        end else if (pick < 3) begin
          queue_step_pair();
        end else begin
          queue_ones($urandom_range(0, 3));
          queue_read((pick == 3) ? extreme_word() : SAMPLE_W'($urandom));
        end
      end
      wait_quiet();
    end

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
